FILE: design/bds_pkg.sv
// Shared constants and register codes for the 2x2 box downsampler.
// Used by the channel interfaces and by box_downsample_2x2_rgb_core.
// No dependencies.
`default_nettype none

package bds_pkg;

  // Default build parameters.
  localparam int unsigned MAX_PAIR_COLUMNS_DEF = 512;
  localparam int unsigned CHANNEL_BITS_DEF     = 8;

  // Fixed register widths and limits.
  localparam int unsigned COL_REG_W       = 10;
  localparam int unsigned ROW_REG_W       = 13;
  localparam int unsigned PAIR_ROWS_LIMIT = 4096;
  localparam int unsigned ROW_POS_W       = $clog2(PAIR_ROWS_LIMIT);

  // Configuration port: two 32-bit registers at byte offsets 0 and 4.
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  typedef enum logic {
    REG_PAIR_COLUMNS = 1'b0,
    REG_PAIR_ROWS    = 1'b1
  } reg_idx_t;

endpackage : bds_pkg

`default_nettype wire

FILE: design/bds_pix_if.sv
// Input pixel channel: valid/ready handshake with one RGB pixel per word.
// Depends on bds_pkg for the default channel width.
`default_nettype none

interface bds_pix_if #(
  parameter int unsigned CHANNEL_BITS = bds_pkg::CHANNEL_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] pix_red;
  logic [CHANNEL_BITS-1:0] pix_green;
  logic [CHANNEL_BITS-1:0] pix_blue;

  modport source (output valid, output pix_red, output pix_green, output pix_blue,
                  input ready);
  modport sink (input valid, input pix_red, input pix_green, input pix_blue,
                output ready);
endinterface : bds_pix_if

`default_nettype wire

FILE: design/bds_avg_if.sv
// Output channel: valid/ready handshake with one averaged pixel per word.
// Depends on bds_pkg for the default channel width.
`default_nettype none

interface bds_avg_if #(
  parameter int unsigned CHANNEL_BITS = bds_pkg::CHANNEL_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] avg_red;
  logic [CHANNEL_BITS-1:0] avg_green;
  logic [CHANNEL_BITS-1:0] avg_blue;
  logic                    area_done;

  modport source (output valid, output avg_red, output avg_green, output avg_blue,
                  output area_done, input ready);
  modport sink (input valid, input avg_red, input avg_green, input avg_blue,
                input area_done, output ready);
endinterface : bds_avg_if

`default_nettype wire

FILE: design/box_downsample_2x2_rgb_core.sv
// A result word is valid in the cycle after the lower-right pixel of its block is taken.
// Throughput: one pixel per cycle; the input stalls only while the output register is
// full and the output side is not ready.
// The line store has one write port and one registered read port; the upper sum is
// fetched when the lower-left pixel arrives. Reset (rst, synchronous) clears positions,
// phase bits and registers (both to 1); the line store is not cleared and needs no pass.
`default_nettype none

module box_downsample_2x2_rgb_core #(
  parameter int unsigned MAX_PAIR_COLUMNS = bds_pkg::MAX_PAIR_COLUMNS_DEF,
  parameter int unsigned CHANNEL_BITS     = bds_pkg::CHANNEL_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  bds_pix_if.sink                            pix,
  bds_avg_if.source                          avg,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bds_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [bds_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [bds_pkg::APB_DATA_W-1:0] prdata,
  output logic                               pready
);
  import bds_pkg::*;

  localparam int unsigned ADDR_W = (MAX_PAIR_COLUMNS > 1) ? $clog2(MAX_PAIR_COLUMNS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_PAIR_COLUMNS + 1);
  localparam int unsigned SUM_W  = CHANNEL_BITS + 1;
  localparam int unsigned TOT_W  = CHANNEL_BITS + 2;
  localparam int unsigned LINE_W = 3 * SUM_W;

  // Configuration registers.
  logic [CNT_W-1:0]     pair_columns;
  logic [ROW_REG_W-1:0] pair_rows;

  // Position and phase.
  logic [ADDR_W-1:0]    column_pos;
  logic [ROW_POS_W-1:0] row_pos;
  logic                 right_half;
  logic                 lower_row;

  logic [CHANNEL_BITS-1:0] left_red;
  logic [CHANNEL_BITS-1:0] left_green;
  logic [CHANNEL_BITS-1:0] left_blue;

  logic [LINE_W-1:0] line_mem [MAX_PAIR_COLUMNS];
  logic [LINE_W-1:0] line_rd;

  // Output register.
  logic                    out_valid;
  logic [CHANNEL_BITS-1:0] out_red;
  logic [CHANNEL_BITS-1:0] out_green;
  logic [CHANNEL_BITS-1:0] out_blue;
  logic                    out_done;

  logic                 cfg_wr;
  reg_idx_t             cfg_idx;
  logic [COL_REG_W-1:0] wr_col;
  logic [ROW_REG_W-1:0] wr_row;
  logic [CNT_W-1:0]     pair_columns_next;
  logic [ROW_REG_W-1:0] pair_rows_next;

  logic              accept;
  logic              last_col;
  logic              last_row;
  logic              emit;
  logic [SUM_W-1:0]  sum_red;
  logic [SUM_W-1:0]  sum_green;
  logic [SUM_W-1:0]  sum_blue;
  logic [TOT_W-1:0]  tot_red;
  logic [TOT_W-1:0]  tot_green;
  logic [TOT_W-1:0]  tot_blue;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[2]);
  assign wr_col  = pwdata[COL_REG_W-1:0];
  assign wr_row  = pwdata[ROW_REG_W-1:0];

  always_comb begin
    if (wr_col == '0) begin
      pair_columns_next = CNT_W'(1);
    end else if (32'(wr_col) > MAX_PAIR_COLUMNS) begin
      pair_columns_next = CNT_W'(MAX_PAIR_COLUMNS);
    end else begin
      pair_columns_next = CNT_W'(wr_col);
    end
    if (wr_row == '0) begin
      pair_rows_next = ROW_REG_W'(1);
    end else if (32'(wr_row) > PAIR_ROWS_LIMIT) begin
      pair_rows_next = ROW_REG_W'(PAIR_ROWS_LIMIT);
    end else begin
      pair_rows_next = wr_row;
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_PAIR_COLUMNS: prdata = APB_DATA_W'(pair_columns);
      REG_PAIR_ROWS:    prdata = APB_DATA_W'(pair_rows);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_columns <= CNT_W'(1);
      pair_rows    <= ROW_REG_W'(1);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_PAIR_COLUMNS: pair_columns <= pair_columns_next;
        REG_PAIR_ROWS:    pair_rows    <= pair_rows_next;
        default:          ;
      endcase
    end
  end

  // ---------------- datapath ----------------
  assign pix.ready = !out_valid || avg.ready;
  assign accept    = pix.valid && pix.ready;
  assign last_col  = (CNT_W'(column_pos) + CNT_W'(1)) == pair_columns;
  assign last_row  = (ROW_REG_W'(row_pos) + ROW_REG_W'(1)) == pair_rows;
  assign emit      = accept && right_half && lower_row;

  assign sum_red   = SUM_W'(left_red) + SUM_W'(pix.pix_red);
  assign sum_green = SUM_W'(left_green) + SUM_W'(pix.pix_green);
  assign sum_blue  = SUM_W'(left_blue) + SUM_W'(pix.pix_blue);

  assign tot_red   = TOT_W'(line_rd[SUM_W-1:0]) + TOT_W'(sum_red);
  assign tot_green = TOT_W'(line_rd[2*SUM_W-1:SUM_W]) + TOT_W'(sum_green);
  assign tot_blue  = TOT_W'(line_rd[3*SUM_W-1:2*SUM_W]) + TOT_W'(sum_blue);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_pos <= '0;
      row_pos    <= '0;
      right_half <= 1'b0;
      lower_row  <= 1'b0;
    end else if (cfg_wr) begin
      column_pos <= '0;
      row_pos    <= '0;
      right_half <= 1'b0;
      lower_row  <= 1'b0;
    end else if (accept) begin
      if (!right_half) begin
        right_half <= 1'b1;
      end else begin
        right_half <= 1'b0;
        if (last_col) begin
          column_pos <= '0;
          if (lower_row) begin
            lower_row <= 1'b0;
            row_pos   <= last_row ? '0 : ROW_POS_W'(row_pos + 1'b1);
          end else begin
            lower_row <= 1'b1;
          end
        end else begin
          column_pos <= ADDR_W'(column_pos + 1'b1);
        end
      end
    end
  end

  // The left pixel is always rewritten before the right pixel reads it.
  always_ff @(posedge clk) begin
    if (accept && !right_half) begin
      left_red   <= pix.pix_red;
      left_green <= pix.pix_green;
      left_blue  <= pix.pix_blue;
    end
  end

  // Upper rows write pair sums; the lower-left pixel fetches the sum for its column,
  // which then holds until the matching right pixel arrives.
  always_ff @(posedge clk) begin
    if (accept && right_half && !lower_row) begin
      line_mem[column_pos] <= {sum_blue, sum_green, sum_red};
    end
    if (accept && !right_half && lower_row) begin
      line_rd <= line_mem[column_pos];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (avg.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_red   <= tot_red[TOT_W-1:2];
      out_green <= tot_green[TOT_W-1:2];
      out_blue  <= tot_blue[TOT_W-1:2];
      out_done  <= last_col && last_row;
    end
  end

  assign avg.valid     = out_valid;
  assign avg.avg_red   = out_red;
  assign avg.avg_green = out_green;
  assign avg.avg_blue  = out_blue;
  assign avg.area_done = out_done;

  // ---------------- assertions ----------------
  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    CNT_W'(column_pos) < pair_columns)
    else $error("column position beyond configured width");

  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    ROW_REG_W'(row_pos) < pair_rows)
    else $error("row position beyond configured height");

  a_valid_from_item: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(accept && right_half && lower_row))
    else $error("result word raised without a lower-right pixel");

  a_area_wrap: assert property (@(posedge clk) disable iff (rst)
    (emit && last_col && last_row && !cfg_wr) |=>
      (row_pos == '0 && column_pos == '0 && !lower_row && !right_half && out_done))
    else $error("area end did not restart the position counters");

endmodule : box_downsample_2x2_rgb_core

`default_nettype wire
